// ===== hw/rtl/adp_pkg.sv =====
`default_nettype none
package adp_pkg;

  localparam int IDX_W        = 12;
  localparam int DATA_W       = 32;
  localparam int ACC_W        = 64;
  localparam int STAB_W       = 13;
  localparam int ROOT_W       = 32;
  localparam int DEN_W        = 33;
  localparam int QUO_W        = 34;
  localparam int ROOT_STEPS   = 32;
  localparam int ELEMENTS_DEF = 4096;

  localparam logic [DATA_W-1:0] LR_RESET   = 32'd655;
  localparam logic [STAB_W-1:0] STAB_RESET = 13'd1;

  // largest update magnitude kept before the final add
  localparam logic [QUO_W-1:0]  MAG_MAX = 34'h2_0000_0000;
  localparam logic signed [35:0] RES_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] RES_MIN = 36'shF_8000_0000;

  typedef enum logic {
    REG_LR   = 1'b0,
    REG_STAB = 1'b1
  } cfg_reg_e;

  // what rides along with an element through the root and divide pipelines
  typedef struct packed {
    logic signed [DATA_W-1:0] param;
    logic                     gneg;
    logic [ACC_W-1:0]         num;
    logic                     sat;
  } adp_side_t;

  // partial remainder of v by elems: conditional subtracts of elems << k, k = hi..lo
  function automatic logic [IDX_W-1:0] idx_reduce(logic [IDX_W-1:0] v, int elems,
                                                  int hi, int lo);
    logic [IDX_W-1:0] r;
    logic [32:0]      m;
    r = v;
    for (int k = hi; k >= lo; k--) begin
      m = 33'(elems) << k;
      if ({21'b0, r} >= m) begin
        r = r - m[IDX_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/adp_ram.sv =====
`default_nettype none
module adp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/adp_acc.sv =====
`default_nettype none
module adp_acc #(
  parameter int ELEMENTS = adp_pkg::ELEMENTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          take_i,
  input  wire logic [adp_pkg::IDX_W-1:0]     idx_i,
  input  wire logic signed [adp_pkg::DATA_W-1:0] param_i,
  input  wire logic signed [adp_pkg::DATA_W-1:0] grad_i,
  input  wire logic [adp_pkg::DATA_W-1:0]    lr_i,
  output logic                               busy_o,
  output logic                               vld_o,
  output logic [adp_pkg::ACC_W-1:0]          acc_o,
  output adp_pkg::adp_side_t                 side_o
);
  import adp_pkg::*;

  localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  // clearing sweep
  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;

  // stage 0: input beat
  logic                     s0_v_q;
  logic [IDX_W-1:0]         s0_idx_q;
  logic signed [DATA_W-1:0] s0_par_q, s0_grd_q;
  // stage 1: square, upper index reduction
  logic                     s1_v_q;
  logic [IDX_W-1:0]         s1_idx_q;
  logic signed [DATA_W-1:0] s1_par_q;
  logic                     s1_gneg_q;
  logic [DATA_W-1:0]        s1_gmag_q;
  logic [ACC_W-1:0]         s1_sq_q;
  // stage 2: memory read returned
  logic                     s2_v_q;
  logic [AW-1:0]            s2_addr_q;
  logic signed [DATA_W-1:0] s2_par_q;
  logic                     s2_gneg_q;
  logic [ACC_W-1:0]         s2_sq_q, s2_num_q;
  // stage 3: new accumulator
  logic                     s3_v_q;
  logic [AW-1:0]            s3_addr_q;
  logic [ACC_W-1:0]         s3_acc_q;
  adp_side_t                s3_side_q;

  logic                     gneg;
  logic [DATA_W-1:0]        gmag;
  logic [IDX_W-1:0]         idx_hi, idx_lo;
  logic [AW-1:0]            raddr;
  logic [ACC_W-1:0]         rdata, old_acc, acc_new;
  logic [ACC_W:0]           acc_sum;
  logic                     acc_ovf;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ACC_W-1:0]         ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == AW'(ELEMENTS - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign gneg   = s0_grd_q[DATA_W-1];
  // most negative gradient maps to 2^31, which the unsigned form holds
  assign gmag   = gneg ? DATA_W'(-s0_grd_q) : DATA_W'(s0_grd_q);
  assign idx_hi = idx_reduce(s0_idx_q, ELEMENTS, 11, 6);
  assign idx_lo = idx_reduce(s1_idx_q, ELEMENTS, 5, 0);
  assign raddr  = AW'(idx_lo);

  // the previous element was written at the same edge this one read
  assign old_acc = (s3_v_q && s3_addr_q == s2_addr_q) ? s3_acc_q : rdata;
  assign acc_sum = {1'b0, old_acc} + {1'b0, s2_sq_q};
  assign acc_ovf = acc_sum[ACC_W];
  assign acc_new = acc_ovf ? '1 : acc_sum[ACC_W-1:0];

  assign ram_we    = clearing_q || (en_i && s2_v_q);
  assign ram_waddr = clearing_q ? clr_cnt_q : s2_addr_q;
  assign ram_wdata = clearing_q ? '0 : acc_new;

  adp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= take_i && !clearing_q;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_idx_q  <= idx_i;
      s0_par_q  <= param_i;
      s0_grd_q  <= grad_i;

      s1_idx_q  <= idx_hi;
      s1_par_q  <= s0_par_q;
      s1_gneg_q <= gneg;
      s1_gmag_q <= gmag;
      s1_sq_q   <= gmag * gmag;

      s2_addr_q <= raddr;
      s2_par_q  <= s1_par_q;
      s2_gneg_q <= s1_gneg_q;
      s2_sq_q   <= s1_sq_q;
      s2_num_q  <= lr_i * s1_gmag_q;

      s3_addr_q       <= s2_addr_q;
      s3_acc_q        <= acc_new;
      s3_side_q.param <= s2_par_q;
      s3_side_q.gneg  <= s2_gneg_q;
      s3_side_q.num   <= s2_num_q;
      s3_side_q.sat   <= acc_ovf;
    end
  end

  assign busy_o = clearing_q;
  assign vld_o  = s3_v_q;
  assign acc_o  = s3_acc_q;
  assign side_o = s3_side_q;

endmodule
`default_nettype wire

// ===== hw/rtl/adp_sqrt.sv =====
`default_nettype none
module adp_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic [adp_pkg::ACC_W-1:0] x_i,
  input  wire adp_pkg::adp_side_t        side_i,
  output logic                           vld_o,
  output logic [adp_pkg::ROOT_W-1:0]     root_o,
  output adp_pkg::adp_side_t             side_o
);
  import adp_pkg::*;

  wire             v_w    [ROOT_STEPS+1];
  wire [ACC_W-1:0] x_w    [ROOT_STEPS+1];
  wire [ACC_W-1:0] r_w    [ROOT_STEPS+1];
  adp_side_t       side_w [ROOT_STEPS+1];

  assign v_w[0]    = vld_i;
  assign x_w[0]    = x_i;
  assign r_w[0]    = '0;
  assign side_w[0] = side_i;

  // one result bit per stage, digit-by-digit from the top pair of bits down
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (62 - 2 * j);
    logic             v_q;
    logic [ACC_W-1:0] x_q, r_q;
    adp_side_t        side_q;
    logic [ACC_W-1:0] trial;
    logic             fits;

    assign trial = r_w[j] + BIT;
    assign fits  = x_w[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= fits ? x_w[j] - trial : x_w[j];
        r_q    <= fits ? (r_w[j] >> 1) + BIT : r_w[j] >> 1;
        side_q <= side_w[j];
      end
    end

    assign v_w[j+1]    = v_q;
    assign x_w[j+1]    = x_q;
    assign r_w[j+1]    = r_q;
    assign side_w[j+1] = side_q;
  end

  assign vld_o  = v_w[ROOT_STEPS];
  assign root_o = r_w[ROOT_STEPS][ROOT_W-1:0];
  assign side_o = side_w[ROOT_STEPS];

endmodule
`default_nettype wire

// ===== hw/rtl/adp_div.sv =====
`default_nettype none
module adp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       vld_i,
  input  wire logic [adp_pkg::ROOT_W-1:0] root_i,
  input  wire logic [adp_pkg::STAB_W-1:0] stab_i,
  input  wire adp_pkg::adp_side_t         side_i,
  output logic                            vld_o,
  output logic signed [adp_pkg::DATA_W-1:0] new_param_o,
  output logic                            sat_o
);
  import adp_pkg::*;

  localparam int SH_W = ACC_W + 3;

  // d0: denominator
  logic             d0_v_q;
  logic [DEN_W-1:0] d0_den_q;
  adp_side_t        d0_side_q;
  // d1: overflow check against den << QUO_W
  logic             d1_v_q, d1_ovf_q;
  logic [DEN_W-1:0] d1_den_q;
  adp_side_t        d1_side_q;
  // mag stage
  logic             m_v_q, m_gneg_q, m_sat_q;
  logic [QUO_W-1:0] m_mag_q;
  logic signed [DATA_W-1:0] m_par_q;

  logic             ovf;
  logic [QUO_W-1:0] mag;
  logic signed [35:0] res;

  assign ovf = {3'b0, d0_side_q.num} >= (SH_W'(d0_den_q) << QUO_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_v_q <= 1'b0;
      d1_v_q <= 1'b0;
    end else if (en_i) begin
      d0_v_q <= vld_i;
      d1_v_q <= d0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_den_q  <= {1'b0, root_i} + DEN_W'(stab_i);
      d0_side_q <= side_i;
      d1_den_q  <= d0_den_q;
      d1_ovf_q  <= ovf;
      d1_side_q <= d0_side_q;
    end
  end

  wire             v_w    [QUO_W+1];
  wire [ACC_W-1:0] rem_w  [QUO_W+1];
  wire [QUO_W-1:0] q_w    [QUO_W+1];
  wire [DEN_W-1:0] den_w  [QUO_W+1];
  wire             ovf_w  [QUO_W+1];
  adp_side_t       side_w [QUO_W+1];

  assign v_w[0]    = d1_v_q;
  assign rem_w[0]  = d1_side_q.num;
  assign q_w[0]    = '0;
  assign den_w[0]  = d1_den_q;
  assign ovf_w[0]  = d1_ovf_q;
  assign side_w[0] = d1_side_q;

  // restoring divide, quotient bit k = QUO_W-1-s at stage s
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int K = QUO_W - 1 - s;
    logic             v_q, ovf_q;
    logic [ACC_W-1:0] rem_q;
    logic [QUO_W-1:0] q_q;
    logic [DEN_W-1:0] den_q;
    adp_side_t        side_q;
    logic [SH_W-1:0]  dsh;
    logic             fits;

    assign dsh  = SH_W'(den_w[s]) << K;
    assign fits = {3'b0, rem_w[s]} >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= fits ? rem_w[s] - dsh[ACC_W-1:0] : rem_w[s];
        q_q    <= q_w[s] | (QUO_W'(fits) << K);
        den_q  <= den_w[s];
        ovf_q  <= ovf_w[s];
        side_q <= side_w[s];
      end
    end

    assign v_w[s+1]    = v_q;
    assign rem_w[s+1]  = rem_q;
    assign q_w[s+1]    = q_q;
    assign den_w[s+1]  = den_q;
    assign ovf_w[s+1]  = ovf_q;
    assign side_w[s+1] = side_q;
  end

  always_comb begin
    if (den_w[QUO_W] == '0) begin
      mag = '0;
    end else if (ovf_w[QUO_W] || q_w[QUO_W] > MAG_MAX) begin
      mag = MAG_MAX;
    end else begin
      mag = q_w[QUO_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en_i) begin
      m_v_q <= v_w[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_mag_q  <= mag;
      m_par_q  <= side_w[QUO_W].param;
      m_gneg_q <= side_w[QUO_W].gneg;
      m_sat_q  <= side_w[QUO_W].sat;
    end
  end

  // update carries the opposite of the gradient's sign
  assign res = m_gneg_q ? 36'(m_par_q) + $signed({2'b0, m_mag_q})
                        : 36'(m_par_q) - $signed({2'b0, m_mag_q});

  always_comb begin
    sat_o = m_sat_q;
    if (res > RES_MAX) begin
      new_param_o = RES_MAX[DATA_W-1:0];
      sat_o       = 1'b1;
    end else if (res < RES_MIN) begin
      new_param_o = RES_MIN[DATA_W-1:0];
      sat_o       = 1'b1;
    end else begin
      new_param_o = res[DATA_W-1:0];
    end
  end

  assign vld_o = m_v_q;

endmodule
`default_nettype wire

// ===== hw/rtl/adagrad_param_update.sv =====
// Throughput: one element per cycle while in_stall_o is low; the 32-stage root
// and 34-stage divide pipelines each take one result bit per stage.
// Reset: asynchronous, active low. After reset every entry of the accumulator
// memory (ELEMENTS, 4096 by default) is swept to zero with in_stall_o high.
`default_nettype none
module adagrad_param_update #(
  parameter int ELEMENTS = adp_pkg::ELEMENTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [adp_pkg::IDX_W-1:0]         element_index_i,
  input  wire logic signed [adp_pkg::DATA_W-1:0] param_value_i,
  input  wire logic signed [adp_pkg::DATA_W-1:0] gradient_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [adp_pkg::DATA_W-1:0]      new_param_o,
  output logic                                   saturated_o,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [adp_pkg::DATA_W-1:0]        cfg_data_i
);
  import adp_pkg::*;

  logic [DATA_W-1:0] lr_q;
  logic [STAB_W-1:0] stab_q;
  logic              en, busy;
  logic              acc_vld, sq_vld, div_vld, div_sat;
  logic [ACC_W-1:0]  acc;
  logic [ROOT_W-1:0] root;
  adp_side_t         acc_side, sq_side;
  logic signed [DATA_W-1:0] div_par;
  logic              out_valid_q, sat_q;
  logic signed [DATA_W-1:0] new_param_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LR_RESET;
      stab_q <= STAB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LR:   lr_q   <= cfg_data_i;
        REG_STAB: stab_q <= cfg_data_i[STAB_W-1:0];
        default:  ;
      endcase
    end
  end

  // whole pipeline moves unless a finished beat is held at the output
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en || busy;

  adp_acc #(
    .ELEMENTS (ELEMENTS)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .take_i  (in_valid_i),
    .idx_i   (element_index_i),
    .param_i (param_value_i),
    .grad_i  (gradient_i),
    .lr_i    (lr_q),
    .busy_o  (busy),
    .vld_o   (acc_vld),
    .acc_o   (acc),
    .side_o  (acc_side)
  );

  adp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (acc_vld),
    .x_i    (acc),
    .side_i (acc_side),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  adp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .vld_i       (sq_vld),
    .root_i      (root),
    .stab_i      (stab_q),
    .side_i      (sq_side),
    .vld_o       (div_vld),
    .new_param_o (div_par),
    .sat_o       (div_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_param_q <= div_par;
      sat_q       <= div_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_param_o = new_param_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

// ===== hw/rtl/adp_checker.sv =====
`default_nettype none
module adp_props (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [adp_pkg::DATA_W-1:0] new_param_o,
  input wire logic                              saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(new_param_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // a held result freezes the pipeline, so the input must stall too
  a_backpress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

  // memory sweep runs right after reset
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input open during clearing sweep");

endmodule

bind adagrad_param_update adp_props u_props (.*);
`default_nettype wire

// ===== test/adp_checker.sv =====
`timescale 1ns / 1ps
module adp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [adp_pkg::IDX_W-1:0]         element_index_i,
  input  logic signed [adp_pkg::DATA_W-1:0] param_value_i,
  input  logic signed [adp_pkg::DATA_W-1:0] gradient_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [adp_pkg::DATA_W-1:0] new_param_i,
  input  logic                              saturated_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [adp_pkg::DATA_W-1:0]        cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  import adp_pkg::*;

  typedef struct {
    logic signed [31:0] new_param;
    logic               sat;
  } update_t;

  logic [63:0]  grad_sq_sum [ELEMENTS_DEF];
  logic [31:0]  alpha;
  logic [12:0]  eps;
  update_t      expected_updates[$];

  function automatic update_t predict_update(logic [11:0] idx, logic signed [31:0] p,
                                             logic signed [31:0] g);
    update_t            u;
    logic [31:0]        gmag;
    logic [64:0]        sum;
    logic [63:0]        acc;
    logic [63:0]        trial;
    logic [31:0]        root;
    logic [63:0]        den;
    logic [63:0]        mag;
    logic signed [35:0] r;
    u.sat = 1'b0;
    gmag = g[31] ? (~g + 32'd1) : g;
    sum = {1'b0, grad_sq_sum[idx]} + {1'b0, {32'b0, gmag} * {32'b0, gmag}};
    if (sum[64]) begin
      acc = '1;
      u.sat = 1'b1;
    end else begin
      acc = sum[63:0];
    end
    grad_sq_sum[idx] = acc;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'b0, root | (32'd1 << b)};
      if (trial * trial <= acc) root = root | (32'd1 << b);
    end
    den = {32'b0, root} + {51'b0, eps};
    mag = (den == 0) ? 64'd0 : ({32'b0, alpha} * {32'b0, gmag}) / den;
    if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
    r = 36'(p);
    r = g[31] ? r + $signed({2'b0, mag[33:0]}) : r - $signed({2'b0, mag[33:0]});
    if (r > RES_MAX) begin
      r = RES_MAX;
      u.sat = 1'b1;
    end else if (r < RES_MIN) begin
      r = RES_MIN;
      u.sat = 1'b1;
    end
    u.new_param = r[31:0];
    return u;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    update_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ELEMENTS_DEF; i++) grad_sq_sum[i] = '0;
      alpha = LR_RESET;
      eps = STAB_RESET;
      expected_updates.delete();
      fail_count_o = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LR) alpha = cfg_data_i;
        else eps = cfg_data_i[12:0];
      end
      if (in_valid_i && !in_stall_i)
        expected_updates.push_back(predict_update(element_index_i, param_value_i,
                                                  gradient_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_updates.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result beat: %h sat %b",
                                           new_param_i, saturated_i);
        end else begin
          want = expected_updates.pop_front();
          if (want.new_param !== new_param_i || want.sat !== saturated_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: new_param exp %h got %h, saturated exp %b got %b",
                       want.new_param, new_param_i, want.sat, saturated_i);
          end
        end
      end
      pending_o = expected_updates.size();
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import adp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [11:0]        element_index_i = '0;
  logic signed [31:0] param_value_i = '0;
  logic signed [31:0] gradient_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] new_param_o;
  logic               saturated_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [31:0]        cfg_data_i = '0;

  int fail_count, pending, checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  always #1 clk_i = ~clk_i;

  adagrad_param_update dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .element_index_i, .param_value_i,
    .gradient_i, .out_valid_o, .out_stall_i, .new_param_o, .saturated_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  adp_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .element_index_i,
    .param_value_i, .gradient_i, .out_valid_i(out_valid_o), .out_stall_i,
    .new_param_i(new_param_o), .saturated_i(saturated_o), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic send_beat(logic [11:0] idx, logic signed [31:0] p, logic signed [31:0] g);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_index_i <= idx;
    param_value_i <= p;
    gradient_i <= g;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e r, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [11:0]        idx;
    logic signed [31:0] p, g;
    idx = $urandom_range(1, 0) ? 12'($urandom_range(15, 0)) : 12'($urandom);
    case ($urandom_range(4, 0))
      0: g = 32'sd0;
      1: g = $urandom_range(1, 0) ? 32'($urandom_range(65535, 0))
                                  : -32'($urandom_range(65535, 0));
      2: g = $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: g = $urandom;
    endcase
    case ($urandom_range(3, 0))
      0: p = $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: p = 32'($signed(16'($urandom)));
      default: p = $urandom;
    endcase
    send_beat(idx, p, g);
  endtask

  initial begin
    logic [31:0] lr_set [5];
    logic [31:0] eps_set [5];
    lr_set = '{32'd655, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0};
    eps_set = '{32'd1, 32'd0, 32'd8191, 32'd6553, 32'd0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero denominator, field extremes, both clamp directions, acc clamp
    cfg_write(REG_LR, 32'h0001_0000);
    cfg_write(REG_STAB, 32'd0);
    send_beat(12'd5, 32'sd123, 32'sd0);
    send_beat(12'd4095, 32'h7FFF_FFFF, 32'sd1);
    send_beat(12'd0, 32'h8000_0000, -32'sd1);
    send_beat(12'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(12'd2, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(12'd3, 32'h8000_0000, 32'sd100);
    repeat (5) send_beat(12'd7, 32'sd0, 32'h8000_0000);
    send_beat(12'd7, 32'sd0, 32'sd0);
    drain();
    cfg_write(REG_STAB, 32'd8191);
    send_beat(12'd5, 32'sd0, 32'h7FFF_FFFF);
    send_beat(12'd6, 32'sd0, -32'sd1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 77 : 0;
      recv_stall_pct = (ph == 0) ? 77 : (ph == 1) ? 9 : 0;
      if (ph == 4) begin
        lr_set[4] = $urandom;
        eps_set[4] = $urandom_range(8191, 0);
      end
      cfg_write(REG_LR, lr_set[ph]);
      cfg_write(REG_STAB, eps_set[ph]);
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 60) hold_left = 400;
        if (ph == 3 && n == 90) drain();
        send_random();
      end
      drain();
    end

    $display("sent %0d update beats, checked %0d results over 5 register settings",
             sent, checked);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/adp_pkg.sv
hw/rtl/adp_ram.sv
hw/rtl/adp_acc.sv
hw/rtl/adp_sqrt.sv
hw/rtl/adp_div.sv
hw/rtl/adagrad_param_update.sv
hw/rtl/adp_checker.sv
test/adp_checker.sv
test/tb_top.sv
